// ----- design/momau_pkg.sv -----
// shared constants, types and codes for the monomial order and arithmetic unit
package momau_pkg;

  localparam int NUM_VARS  = 8;
  localparam int EXP_BITS  = 8;
  localparam int MONO_W    = 64;
  localparam int PAIRS     = (NUM_VARS + 1) / 2;
  localparam int PAIR_W    = EXP_BITS + 1;
  localparam int DEG_W     = 11;
  localparam int MODE_W    = 3;
  localparam int ORDER_W   = 2;
  localparam int ORD_RES_W = 2;
  localparam int STATUS_W  = 2;

  localparam int IN_TDATA_W = 2 * MONO_W;

  localparam int RES_LSB     = 0;
  localparam int ORD_LSB     = RES_LSB + MONO_W;
  localparam int TEST_BIT    = ORD_LSB + ORD_RES_W;
  localparam int DEG_LSB     = TEST_BIT + 1;
  localparam int STAT_LSB    = DEG_LSB + DEG_W;
  localparam int OUT_W       = STAT_LSB + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [EXP_BITS-1:0]         exp_t;
  typedef logic [MONO_W-1:0]           mono_t;
  typedef logic [NUM_VARS-1:0]         lanes_t;
  typedef logic [PAIR_W-1:0]           pair_t;
  typedef logic [DEG_W-1:0]            deg_t;
  typedef logic signed [ORD_RES_W-1:0] ord_res_t;

  localparam exp_t     EXP_MAX = '1;
  localparam ord_res_t ORD_GT  = 2'sb01;
  localparam ord_res_t ORD_EQ  = 2'sb00;
  localparam ord_res_t ORD_LT  = 2'sb11;

  typedef enum logic [MODE_W-1:0] {
    MODE_CMP     = 3'd0,
    MODE_MUL     = 3'd1,
    MODE_DIV     = 3'd2,
    MODE_LCM     = 3'd3,
    MODE_DIVTEST = 3'd4,
    MODE_COPRIME = 3'd5,
    MODE_DEG     = 3'd6
  } mode_t;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_LEX     = 2'd0,
    ORDER_REVLEX  = 2'd1,
    ORDER_GRLEX   = 2'd2,
    ORDER_GREVLEX = 2'd3
  } order_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_DIV  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                 mode;
    mono_t                 lhs;
    mono_t                 prod;
    mono_t                 quot;
    mono_t                 lcm;
    logic                  ovf;
    logic                  divisible;
    logic                  coprime;
    lanes_t                gt;
    lanes_t                lt;
    pair_t [PAIRS-1:0]     lhs_pair;
    pair_t [PAIRS-1:0]     rhs_pair;
  } s1_t;

  typedef struct packed {
    mode_t    mode;
    mono_t    res;
    logic     test;
    status_t  status;
    deg_t     lhs_deg;
    deg_t     rhs_deg;
    ord_res_t lex_ord;
    ord_res_t rlex_ord;
  } s2_t;

  typedef struct packed {
    status_t  status;
    deg_t     lhs_degree;
    logic     test_result;
    ord_res_t order_result;
    mono_t    result_exponents;
  } out_t;

endpackage

// ----- design/momau_elem.sv -----
// stage 1: per-variable exponent arithmetic and pairwise degree sums
module momau_elem (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                in_valid,
  input  logic [momau_pkg::MODE_W-1:0]        mode,
  input  momau_pkg::mono_t                    lhs,
  input  momau_pkg::mono_t                    rhs,
  output logic                                out_valid,
  output momau_pkg::s1_t                      out
);
  import momau_pkg::*;

  exp_t [NUM_VARS-1:0] lx;
  exp_t [NUM_VARS-1:0] rx;
  s1_t                 calc;
  logic [PAIR_W-1:0]   lane_sum;

  always_comb begin
    calc      = '0;
    calc.mode = mode_t'(mode);
    calc.divisible = 1'b1;
    calc.coprime   = 1'b1;
    lane_sum  = '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      lx[i] = lhs[i*EXP_BITS +: EXP_BITS];
      rx[i] = rhs[i*EXP_BITS +: EXP_BITS];
      lane_sum = {1'b0, lx[i]} + {1'b0, rx[i]};
      calc.lhs[i*EXP_BITS +: EXP_BITS]  = lx[i];
      calc.prod[i*EXP_BITS +: EXP_BITS] = lane_sum[EXP_BITS] ? EXP_MAX
                                                             : lane_sum[EXP_BITS-1:0];
      calc.quot[i*EXP_BITS +: EXP_BITS] = lx[i] - rx[i];
      calc.lcm[i*EXP_BITS +: EXP_BITS]  = (lx[i] > rx[i]) ? lx[i] : rx[i];
      calc.gt[i] = lx[i] > rx[i];
      calc.lt[i] = lx[i] < rx[i];
      if (lane_sum[EXP_BITS]) calc.ovf = 1'b1;
      if (lx[i] < rx[i]) calc.divisible = 1'b0;
      if (lx[i] != '0 && rx[i] != '0) calc.coprime = 1'b0;
    end
    for (int p = 0; p < PAIRS; p++) begin
      if (2 * p + 1 < NUM_VARS) begin
        calc.lhs_pair[p] = {1'b0, lx[2*p]} + {1'b0, lx[2*p+1]};
        calc.rhs_pair[p] = {1'b0, rx[2*p]} + {1'b0, rx[2*p+1]};
      end else begin
        calc.lhs_pair[p] = {1'b0, lx[2*p]};
        calc.rhs_pair[p] = {1'b0, rx[2*p]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out <= calc;
    end
  end

endmodule

// ----- design/momau_reduce.sv -----
// stage 2: degree sums, lex and revlex decisions, result and status selection
module momau_reduce (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            in_valid,
  input  momau_pkg::s1_t  in,
  output logic            out_valid,
  output momau_pkg::s2_t  out
);
  import momau_pkg::*;

  s2_t calc;

  always_comb begin
    calc          = '0;
    calc.mode     = in.mode;
    calc.res      = in.lhs;
    calc.test     = 1'b0;
    calc.status   = STAT_OK;
    calc.lex_ord  = ORD_EQ;
    calc.rlex_ord = ORD_EQ;
    for (int p = 0; p < PAIRS; p++) begin
      calc.lhs_deg = calc.lhs_deg + DEG_W'(in.lhs_pair[p]);
      calc.rhs_deg = calc.rhs_deg + DEG_W'(in.rhs_pair[p]);
    end
    // lowest differing variable wins for lex
    for (int i = NUM_VARS - 1; i >= 0; i--) begin
      if (in.gt[i] || in.lt[i]) calc.lex_ord = in.gt[i] ? ORD_GT : ORD_LT;
    end
    // highest differing variable wins for revlex, smaller exponent ranks higher
    for (int i = 0; i < NUM_VARS; i++) begin
      if (in.gt[i] || in.lt[i]) calc.rlex_ord = in.lt[i] ? ORD_GT : ORD_LT;
    end
    unique case (in.mode)
      MODE_MUL: begin
        calc.res    = in.prod;
        calc.status = in.ovf ? STAT_OVERFLOW : STAT_OK;
      end
      MODE_DIV: begin
        if (in.divisible) calc.res = in.quot;
        else calc.status = STAT_NOT_DIV;
      end
      MODE_LCM:     calc.res  = in.lcm;
      MODE_DIVTEST: calc.test = in.divisible;
      MODE_COPRIME: calc.test = in.coprime;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out <= calc;
    end
  end

endmodule

// ----- design/momau_order.sv -----
// stage 3: degree compare, order selection and output register
module momau_order (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              in_valid,
  input  momau_pkg::order_t order,
  input  momau_pkg::s2_t    in,
  output logic              out_valid,
  output momau_pkg::out_t   out
);
  import momau_pkg::*;

  ord_res_t deg_ord;
  ord_res_t cmp_ord;
  out_t     calc;

  always_comb begin
    if (in.lhs_deg == in.rhs_deg) deg_ord = ORD_EQ;
    else deg_ord = (in.lhs_deg > in.rhs_deg) ? ORD_GT : ORD_LT;
    unique case (order)
      ORDER_LEX:     cmp_ord = in.lex_ord;
      ORDER_REVLEX:  cmp_ord = in.rlex_ord;
      ORDER_GRLEX:   cmp_ord = (deg_ord != ORD_EQ) ? deg_ord : in.lex_ord;
      ORDER_GREVLEX: cmp_ord = (deg_ord != ORD_EQ) ? deg_ord : in.rlex_ord;
      default:       cmp_ord = ORD_EQ;
    endcase
    calc.result_exponents = in.res;
    calc.order_result     = (in.mode == MODE_CMP) ? cmp_ord : ORD_EQ;
    calc.test_result      = in.test;
    calc.lhs_degree       = in.lhs_deg;
    calc.status           = in.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out <= calc;
    end
  end

endmodule

// ----- design/monomial_order_and_arithmetic_unit_top.sv -----
// Monomial order and arithmetic unit, top level. Takes one pair of packed
// monomials per cycle while the output is not stalled and returns one
// result per pair through a three-stage pipeline: per-variable arithmetic,
// then degree sums and lex/revlex decisions, then degree compare and the
// output register. A stall on the output side fills bubbles first and only
// then deasserts s_axis_tready. The compare order is a register written on
// the cfg channel; the user must write it only while no transaction is in
// flight, as the block does not enforce it; cfg_ready is always high.
module monomial_order_and_arithmetic_unit_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [momau_pkg::ORDER_W-1:0]        cfg_data,      // monomial_order
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [momau_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // lhs_exponents, rhs_exponents
  input  logic [momau_pkg::MODE_W-1:0]         s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_exponents, order_result, test_result, lhs_degree, status
  output logic [momau_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import momau_pkg::*;

  order_t order;
  logic   v1, v2, v3;
  logic   rdy1, rdy2, rdy3;
  s1_t    s1;
  s2_t    s2;
  out_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_LEX;
    end else if (cfg_valid) begin
      order <= order_t'(cfg_data);
    end
  end

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  momau_elem u_elem (
    .clk       (clk),
    .rst       (rst),
    .load      (rdy1),
    .in_valid  (s_axis_tvalid),
    .mode      (s_axis_tuser),
    .lhs       (s_axis_tdata[MONO_W-1:0]),
    .rhs       (s_axis_tdata[2*MONO_W-1:MONO_W]),
    .out_valid (v1),
    .out       (s1)
  );

  momau_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .load      (rdy2),
    .in_valid  (v1),
    .in        (s1),
    .out_valid (v2),
    .out       (s2)
  );

  momau_order u_order (
    .clk       (clk),
    .rst       (rst),
    .load      (rdy3),
    .in_valid  (v2),
    .order     (order),
    .in        (s2),
    .out_valid (v3),
    .out       (res)
  );

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = OUT_TDATA_W'(res);

endmodule

// ----- design/momau_checker.sv -----
// port-level checks for the monomial order and arithmetic unit
module momau_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [momau_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import momau_pkg::*;

  logic [ORD_RES_W-1:0] ord_f;
  logic [STATUS_W-1:0]  stat_f;

  assign ord_f  = m_axis_tdata[ORD_LSB +: ORD_RES_W];
  assign stat_f = m_axis_tdata[STAT_LSB +: STATUS_W];

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_order_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ord_f != 2'b10 && stat_f != 2'b11)
    else $error("illegal order or status code");

  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && stat_f != STAT_OK |->
      ord_f == ORD_EQ && !m_axis_tdata[TEST_BIT])
    else $error("status with compare or test result");

endmodule

bind monomial_order_and_arithmetic_unit_top momau_checker u_momau_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_monomial_order_and_arithmetic_unit_top.sv -----
// self-checking testbench for the monomial order and arithmetic unit top level
module tb_monomial_order_and_arithmetic_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import momau_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 205;
  localparam int NUM_PHASES = 6;
  localparam int MAX_REPORTS = 10;

  class monomial_scoreboard;
    order_t order;
    out_t   pending_results[$];
    int     checked;
    int     failures;

    function new();
      order = ORDER_LEX;
      checked = 0;
      failures = 0;
    endfunction

    function out_t compute_monomial_result(logic [MODE_W-1:0] mode, mono_t lhs, mono_t rhs);
      out_t               r;
      exp_t               x;
      exp_t               y;
      logic [EXP_BITS:0]  s;
      mono_t              prod;
      mono_t              quot;
      mono_t              lcm;
      logic               ovf;
      logic               divisible;
      logic               coprime;
      deg_t               lhs_deg;
      deg_t               rhs_deg;
      ord_res_t           lex_res;
      ord_res_t           revlex_res;
      ord_res_t           deg_res;
      prod = '0;
      quot = '0;
      lcm = '0;
      ovf = 1'b0;
      divisible = 1'b1;
      coprime = 1'b1;
      lhs_deg = '0;
      rhs_deg = '0;
      lex_res = ORD_EQ;
      revlex_res = ORD_EQ;
      for (int i = 0; i < NUM_VARS; i++) begin
        x = lhs[i*EXP_BITS +: EXP_BITS];
        y = rhs[i*EXP_BITS +: EXP_BITS];
        s = {1'b0, x} + {1'b0, y};
        if (s > {1'b0, EXP_MAX}) begin
          s = {1'b0, EXP_MAX};
          ovf = 1'b1;
        end
        if (y > x) divisible = 1'b0;
        if (x != 0 && y != 0) coprime = 1'b0;
        prod[i*EXP_BITS +: EXP_BITS] = s[EXP_BITS-1:0];
        quot[i*EXP_BITS +: EXP_BITS] = x - y;
        lcm[i*EXP_BITS +: EXP_BITS] = (x > y) ? x : y;
        lhs_deg += DEG_W'(x);
        rhs_deg += DEG_W'(y);
        // lex keeps the first difference, revlex the last
        if (lex_res == ORD_EQ && x != y) lex_res = (x > y) ? ORD_GT : ORD_LT;
        if (x != y) revlex_res = (x < y) ? ORD_GT : ORD_LT;
      end
      deg_res = (lhs_deg > rhs_deg) ? ORD_GT : (lhs_deg < rhs_deg) ? ORD_LT : ORD_EQ;

      r.result_exponents = lhs;
      r.order_result = ORD_EQ;
      r.test_result = 1'b0;
      r.lhs_degree = lhs_deg;
      r.status = STAT_OK;
      case (mode)
        MODE_CMP: begin
          case (order)
            ORDER_LEX:     r.order_result = lex_res;
            ORDER_REVLEX:  r.order_result = revlex_res;
            ORDER_GRLEX:   r.order_result = (deg_res != ORD_EQ) ? deg_res : lex_res;
            ORDER_GREVLEX: r.order_result = (deg_res != ORD_EQ) ? deg_res : revlex_res;
            default: ;
          endcase
        end
        MODE_MUL: begin
          r.result_exponents = prod;
          r.status = ovf ? STAT_OVERFLOW : STAT_OK;
        end
        MODE_DIV: begin
          if (divisible) r.result_exponents = quot;
          else r.status = STAT_NOT_DIV;
        end
        MODE_LCM:     r.result_exponents = lcm;
        MODE_DIVTEST: r.test_result = divisible;
        MODE_COPRIME: r.test_result = coprime;
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, mono_t lhs, mono_t rhs);
      pending_results.push_back(compute_monomial_result(mode, lhs, rhs));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      out_t got;
      out_t want;
      got = out_t'(tdata);
      checked++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result transaction: %h", tdata);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_exponents !== want.result_exponents ||
          got.order_result !== want.order_result ||
          got.test_result !== want.test_result ||
          got.lhs_degree !== want.lhs_degree ||
          got.status !== want.status) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: want res=%h ord=%0d test=%b deg=%0d status=%0d",
                   want.result_exponents, want.order_result, want.test_result,
                   want.lhs_degree, want.status);
          $display("          got  res=%h ord=%0d test=%b deg=%0d status=%0d",
                   got.result_exponents, got.order_result, got.test_result,
                   got.lhs_degree, got.status);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ORDER_W-1:0]     cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  monomial_scoreboard sb;
  int items_sent = 0;
  int order_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_style = 0;
  int rx_left = 0;
  int rx_run = 0;
  logic rx_hold = 1'b0;

  monomial_order_and_arithmetic_unit_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, switching to a randomly chosen style after each run of random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 256);
      rx_run = 0;
    end
    rx_left--;
    case (rx_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_left % 4) != 0;
      default: begin
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run = rx_hold ? $urandom_range(1, 6) : $urandom_range(1, 15);
        end
        rx_run--;
        m_axis_tready <= rx_hold;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic mono_t gen_mono();
    mono_t m;
    int    kind;
    kind = $urandom_range(0, 4);
    m = {$urandom, $urandom};
    for (int i = 0; i < NUM_VARS; i++) begin
      case (kind)
        1: m[i*EXP_BITS +: EXP_BITS] = $urandom_range(0, 1) ? exp_t'($urandom_range(0, 7)) : '0;
        2: m[i*EXP_BITS +: EXP_BITS] = exp_t'($urandom_range(0, 3));
        3: m[i*EXP_BITS +: EXP_BITS] = ($urandom_range(0, 3) == 0) ? '0 :
                                       exp_t'($urandom_range(240, 255));
        4: begin
          case ($urandom_range(0, 4))
            0: m[i*EXP_BITS +: EXP_BITS] = '0;
            1: m[i*EXP_BITS +: EXP_BITS] = 8'h01;
            2: m[i*EXP_BITS +: EXP_BITS] = 8'h7F;
            3: m[i*EXP_BITS +: EXP_BITS] = 8'h80;
            default: m[i*EXP_BITS +: EXP_BITS] = EXP_MAX;
          endcase
        end
        default: ;
      endcase
    end
    return m;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, mono_t lhs, mono_t rhs);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rhs, lhs};
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(mode, lhs, rhs);
    items_sent++;
  endtask

  task automatic write_order(order_t ord);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.order = ord;
    order_writes++;
  endtask

  initial begin
    mono_t            lhs;
    mono_t            rhs;
    mono_t            tmp;
    exp_t             a;
    exp_t             b;
    int               j;
    int               k;
    logic [MODE_W-1:0] mode;
    order_t           ord;

    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under the reset order
    send_item(MODE_CMP, 64'h0102_0304_0506_0708, 64'h0102_0304_0506_0708);
    send_item(MODE_CMP, '0, '1);
    send_item(MODE_CMP, '1, '0);
    send_item(MODE_CMP, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_0001);
    send_item(MODE_MUL, '0, '0);
    send_item(MODE_MUL, '1, '1);
    send_item(MODE_MUL, 64'h0102_0304_0506_0708, 64'h1020_3040_5060_7080);
    send_item(MODE_MUL, 64'h0000_0000_0000_807F, 64'h0000_0000_0000_8080);
    send_item(MODE_DIV, '1, 64'h0123_4567_89AB_CDEF);
    send_item(MODE_DIV, '0, 64'h0000_0000_0000_0001);
    send_item(MODE_DIV, 64'h0505_0505_0505_0505, 64'h0505_0505_0505_0505);
    send_item(MODE_LCM, '1, '0);
    send_item(MODE_LCM, 64'h00FF_00FF_1234_5678, 64'hFF00_FF00_5678_1234);
    send_item(MODE_DIVTEST, 64'h0203_0405_0607_0809, 64'h0102_0304_0506_0708);
    send_item(MODE_DIVTEST, 64'h0102_0304_0506_0708, 64'h0203_0405_0607_0809);
    send_item(MODE_DIVTEST, '0, '0);
    send_item(MODE_COPRIME, 64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00);
    send_item(MODE_COPRIME, '1, 64'h0000_0000_0000_0001);
    send_item(MODE_COPRIME, '0, '0);
    send_item(MODE_DEG, '1, '0);
    send_item(MODE_DEG, '0, '1);
    send_item(MODE_UNDEF, 64'hDEAD_BEEF_0123_4567, '1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ord = ORDER_REVLEX;
        1: ord = ORDER_GRLEX;
        2: ord = ORDER_GREVLEX;
        3: ord = ORDER_LEX;
        default: ord = order_t'($urandom_range(0, 3));
      endcase
      write_order(ord);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(0, 3) == 0) ? MODE_CMP : 3'($urandom_range(0, 7));
        lhs = gen_mono();
        rhs = lhs;
        j = $urandom_range(0, NUM_VARS - 1);
        k = $urandom_range(0, NUM_VARS - 1);
        case ($urandom_range(0, 6))
          0: rhs = gen_mono();
          1: ;
          2: rhs[j*EXP_BITS +: EXP_BITS] = exp_t'($urandom);
          3: begin
            for (int i = 0; i < NUM_VARS; i++)
              rhs[i*EXP_BITS +: EXP_BITS] = exp_t'($urandom_range(0, lhs[i*EXP_BITS +: EXP_BITS]));
          end
          4: begin
            for (int i = 0; i < NUM_VARS; i++)
              rhs[i*EXP_BITS +: EXP_BITS] = (lhs[i*EXP_BITS +: EXP_BITS] != 0) ? '0 :
                                            exp_t'($urandom_range(0, 1) ? $urandom : 0);
          end
          5: begin
            rhs[j*EXP_BITS +: EXP_BITS] = lhs[k*EXP_BITS +: EXP_BITS];
            rhs[k*EXP_BITS +: EXP_BITS] = lhs[j*EXP_BITS +: EXP_BITS];
          end
          default: begin
            // same degree, one unit moved between two variables
            a = lhs[j*EXP_BITS +: EXP_BITS];
            b = lhs[k*EXP_BITS +: EXP_BITS];
            if (j != k && a != 0 && b != EXP_MAX) begin
              rhs[j*EXP_BITS +: EXP_BITS] = a - 1'b1;
              rhs[k*EXP_BITS +: EXP_BITS] = b + 1'b1;
            end
          end
        endcase
        if ($urandom_range(0, 1)) begin
          tmp = lhs;
          lhs = rhs;
          rhs = tmp;
        end
        send_item(mode, lhs, rhs);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.failures += sb.pending_results.size();

    $display("covered %0d monomial pairs across %0d order writes, all modes and mode 7",
             items_sent, order_writes);
    $display("%0d results checked, %0d failures", sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/momau_pkg.sv
design/momau_elem.sv
design/momau_reduce.sv
design/momau_order.sv
design/monomial_order_and_arithmetic_unit_top.sv
design/momau_checker.sv
tb/tb_monomial_order_and_arithmetic_unit_top.sv
